@@ rtl/klx_pkg.sv @@
// ----------------------------------------------------------------------------
// klx_pkg
// Shared types and constants of the keyword, number and string lexer.
// ----------------------------------------------------------------------------
package klx_pkg;

  localparam int KW_NUM = 9;
  localparam int TLEN_W = 8;

  // token kinds
  localparam logic [2:0] TK_OPEN    = 3'd0;
  localparam logic [2:0] TK_CLOSE   = 3'd1;
  localparam logic [2:0] TK_NUMBER  = 3'd2;
  localparam logic [2:0] TK_KEYWORD = 3'd3;
  localparam logic [2:0] TK_SCHAR   = 3'd4;
  localparam logic [2:0] TK_SEND    = 3'd5;
  localparam logic [2:0] TK_EOL     = 3'd6;
  localparam logic [2:0] TK_ERROR   = 3'd7;

  // error codes
  localparam logic [2:0] ER_UNKNOWN   = 3'd0;
  localparam logic [2:0] ER_UNTERM_KW = 3'd1;
  localparam logic [2:0] ER_UNTERM_ST = 3'd2;
  localparam logic [2:0] ER_NUM_BIG   = 3'd3;
  localparam logic [2:0] ER_TOO_LONG  = 3'd4;
  localparam logic [2:0] ER_EOL_CMT   = 3'd5;

  // characters
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5c;
  localparam logic [7:0] CH_OPEN  = 8'h5b;
  localparam logic [7:0] CH_CLOSE = 8'h5d;

  // keyword texts, last character in the low byte
  localparam logic [71:0] KW_TEXT [KW_NUM] = '{
    72'("chpos"), 72'("cipher"), 72'("date"), 72'("method"), 72'("range"),
    72'("regex"), 72'("seekpoint"), 72'("verbose"), 72'("wordlist")
  };
  localparam logic [3:0] KW_LEN [KW_NUM] = '{
    4'd5, 4'd6, 4'd4, 4'd6, 4'd5, 4'd5, 4'd9, 4'd7, 4'd8
  };

  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  kw_idx;
    logic [10:0] num;
    logic [7:0]  ch;
    logic [2:0]  err;
  } tok_t;

  typedef struct packed {
    tok_t t0;
    tok_t t1;
    logic two;
  } ent_t;

  function automatic tok_t make_tok(logic [2:0] kind, logic [2:0] err);
    tok_t t;
    t = '0;
    t.kind = kind;
    t.err = err;
    return t;
  endfunction

  // keep the candidates whose character at pos equals c
  function automatic logic [KW_NUM-1:0] kw_narrow(logic [KW_NUM-1:0] mask,
                                                  logic [TLEN_W-1:0] pos,
                                                  logic [7:0] c);
    logic [KW_NUM-1:0] res;
    logic [3:0] bi;
    res = '0;
    for (int k = 0; k < KW_NUM; k++) begin
      bi = KW_LEN[k] - 4'd1 - pos[3:0];
      if (mask[k] && pos < TLEN_W'(KW_LEN[k]) && KW_TEXT[k][bi*8 +: 8] == c)
        res[k] = 1'b1;
    end
    return res;
  endfunction

endpackage

@@ rtl/klx_front.sv @@
// ----------------------------------------------------------------------------
// klx_front
// Lexer state machine: classifies each character and forms up to two tokens.
// ----------------------------------------------------------------------------
module klx_front #(
  parameter int MAX_TEXT     = 128,
  parameter int NUMBER_LIMIT = 1024
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          acc,
  input  logic [7:0]    c,
  output logic          push,
  output klx_pkg::ent_t ent
);
  import klx_pkg::*;

  localparam int ACC_MAX = (NUMBER_LIMIT > 9) ? NUMBER_LIMIT : 9;
  localparam int NUM_W   = $clog2(ACC_MAX + 1);
  localparam int VW      = NUM_W + 4;

  localparam logic [2:0] M_START   = 3'd0;
  localparam logic [2:0] M_COMMENT = 3'd1;
  localparam logic [2:0] M_KEYWORD = 3'd2;
  localparam logic [2:0] M_NUMBER  = 3'd3;
  localparam logic [2:0] M_STRING  = 3'd4;
  localparam logic [2:0] M_DISCARD = 3'd5;

  logic [2:0]        mode_r, mode_nxt;
  logic [KW_NUM-1:0] cand_r, cand_nxt;
  logic [TLEN_W-1:0] tlen_r, tlen_nxt;
  logic [NUM_W-1:0]  acc_r, acc_nxt;
  logic              ovf_r, ovf_nxt;
  logic              bsl_r, bsl_nxt;

  logic is_space, is_digit, is_alnum, is_nul, is_eolc;
  logic st_emit;
  tok_t st_tok;
  logic [VW-1:0] v;
  logic kw_hit;
  logic [3:0] kw_k;
  tok_t e0, e1;
  logic e0_v, e1_v;

  assign is_nul   = (c == CH_NUL);
  assign is_eolc  = is_nul || (c == CH_LF);
  assign is_space = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0d);
  assign is_digit = (c >= 8'h30 && c <= 8'h39);
  assign is_alnum = is_digit || (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);

  assign v = (VW'(acc_r) << 3) + (VW'(acc_r) << 1) + VW'(c[3:0]);

  // first candidate whose length equals the stored text length
  always_comb begin
    kw_hit = 1'b0;
    kw_k = '0;
    for (int k = KW_NUM - 1; k >= 0; k--) begin
      if (cand_r[k] && TLEN_W'(KW_LEN[k]) == tlen_r) begin
        kw_hit = 1'b1;
        kw_k = 4'(k);
      end
    end
  end

  always_comb begin
    mode_nxt = mode_r;
    cand_nxt = cand_r;
    tlen_nxt = tlen_r;
    acc_nxt  = acc_r;
    ovf_nxt  = ovf_r;
    bsl_nxt  = bsl_r;
    e0 = '0;
    e1 = '0;
    e0_v = 1'b0;
    e1_v = 1'b0;
    st_emit = 1'b0;
    st_tok = '0;

    case (mode_r)
      M_START: begin
        if (is_nul) begin
          e0_v = 1'b1;
          e0 = make_tok(TK_EOL, 3'd0);
        end else if (c == CH_SEMI && !is_space) begin
          mode_nxt = M_COMMENT;
        end else if (!is_space) begin
          mode_nxt = M_START;
        end
      end
      default: ;
    endcase

    // token start, shared by start mode and re-examined terminators
    if (is_nul) begin
      st_emit = 1'b1;
      st_tok = make_tok(TK_EOL, 3'd0);
    end else if (c == CH_OPEN) begin
      st_emit = 1'b1;
      st_tok = make_tok(TK_OPEN, 3'd0);
    end else if (c == CH_CLOSE) begin
      st_emit = 1'b1;
      st_tok = make_tok(TK_CLOSE, 3'd0);
    end else if (!is_space && c != CH_SEMI && !is_alnum && c != CH_QUOTE) begin
      st_emit = 1'b1;
      st_tok = make_tok(TK_ERROR, ER_UNKNOWN);
    end

    case (mode_r)
      M_START, M_KEYWORD, M_NUMBER: begin
        // decide whether a token start happens this beat
        if (mode_r == M_START ||
            (mode_r == M_KEYWORD && !is_alnum && !is_eolc && kw_hit) ||
            (mode_r == M_NUMBER && !is_digit && !ovf_r)) begin
          if (mode_r == M_KEYWORD) begin
            e0_v = 1'b1;
            e0 = make_tok(TK_KEYWORD, 3'd0);
            e0.kw_idx = kw_k;
          end else if (mode_r == M_NUMBER) begin
            e0_v = 1'b1;
            e0 = make_tok(TK_NUMBER, 3'd0);
            e0.num = 11'(acc_r);
          end
          mode_nxt = M_START;
          if (mode_r == M_START) begin
            e0_v = st_emit;
            e0 = st_tok;
          end else begin
            e1_v = st_emit;
            e1 = st_tok;
          end
          if (is_nul || is_space || c == CH_OPEN || c == CH_CLOSE) begin
            mode_nxt = M_START;
          end else if (c == CH_SEMI) begin
            mode_nxt = M_COMMENT;
          end else if (is_digit) begin
            mode_nxt = M_NUMBER;
            acc_nxt = NUM_W'(c[3:0]);
            ovf_nxt = 1'b0;
          end else if (c == CH_QUOTE) begin
            mode_nxt = M_STRING;
            tlen_nxt = '0;
            bsl_nxt = 1'b0;
          end else if (is_alnum) begin
            mode_nxt = M_KEYWORD;
            cand_nxt = kw_narrow('1, '0, c);
            tlen_nxt = TLEN_W'(1);
          end else begin
            mode_nxt = M_DISCARD;
          end
        end else if (mode_r == M_KEYWORD) begin
          if (is_alnum) begin
            if (tlen_r >= TLEN_W'(MAX_TEXT)) begin
              e0_v = 1'b1;
              e0 = make_tok(TK_ERROR, ER_TOO_LONG);
              mode_nxt = M_DISCARD;
            end else begin
              cand_nxt = kw_narrow(cand_r, tlen_r, c);
              tlen_nxt = tlen_r + TLEN_W'(1);
            end
          end else begin
            e0_v = 1'b1;
            e0 = make_tok(TK_ERROR, is_eolc ? ER_UNTERM_KW : ER_UNKNOWN);
            e1_v = is_nul;
            e1 = make_tok(TK_EOL, 3'd0);
            mode_nxt = is_nul ? M_START : M_DISCARD;
          end
        end else begin
          // number mode
          if (is_digit) begin
            if (ovf_r || v > VW'(NUMBER_LIMIT)) begin
              ovf_nxt = 1'b1;
              acc_nxt = NUM_W'(NUMBER_LIMIT);
            end else begin
              acc_nxt = v[NUM_W-1:0];
            end
          end else begin
            e0_v = 1'b1;
            e0 = make_tok(TK_ERROR, ER_NUM_BIG);
            e1_v = is_nul;
            e1 = make_tok(TK_EOL, 3'd0);
            mode_nxt = is_nul ? M_START : M_DISCARD;
          end
        end
      end
      M_COMMENT: begin
        if (c == CH_LF) begin
          mode_nxt = M_START;
        end else if (is_nul) begin
          e0_v = 1'b1;
          e0 = make_tok(TK_ERROR, ER_EOL_CMT);
          e1_v = 1'b1;
          e1 = make_tok(TK_EOL, 3'd0);
          mode_nxt = M_START;
        end
      end
      M_STRING: begin
        if (is_eolc) begin
          e0_v = 1'b1;
          e0 = make_tok(TK_ERROR, ER_UNTERM_ST);
          e1_v = is_nul;
          e1 = make_tok(TK_EOL, 3'd0);
          mode_nxt = is_nul ? M_START : M_DISCARD;
        end else if (c == CH_QUOTE && !bsl_r) begin
          e0_v = 1'b1;
          e0 = make_tok(TK_SEND, 3'd0);
          mode_nxt = M_START;
        end else if (tlen_r >= TLEN_W'(MAX_TEXT)) begin
          e0_v = 1'b1;
          e0 = make_tok(TK_ERROR, ER_TOO_LONG);
          mode_nxt = M_DISCARD;
        end else begin
          // backslash toggles, anything else clears the escape flag
          bsl_nxt = (c == CH_BSL) ? !bsl_r : 1'b0;
          tlen_nxt = tlen_r + TLEN_W'(1);
          e0_v = 1'b1;
          e0 = make_tok(TK_SCHAR, 3'd0);
          e0.ch = c;
        end
      end
      default: begin
        if (is_nul) begin
          e0_v = 1'b1;
          e0 = make_tok(TK_EOL, 3'd0);
          mode_nxt = M_START;
        end
      end
    endcase
  end

  assign push    = acc && e0_v;
  assign ent.t0  = e0;
  assign ent.t1  = e1;
  assign ent.two = e1_v;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_START;
      cand_r <= '1;
      tlen_r <= '0;
      acc_r  <= '0;
      ovf_r  <= 1'b0;
      bsl_r  <= 1'b0;
    end else if (acc) begin
      mode_r <= mode_nxt;
      cand_r <= cand_nxt;
      tlen_r <= tlen_nxt;
      acc_r  <= acc_nxt;
      ovf_r  <= ovf_nxt;
      bsl_r  <= bsl_nxt;
    end
  end

endmodule

@@ rtl/klx_queue.sv @@
// ----------------------------------------------------------------------------
// klx_queue
// Two-entry queue of token groups between the lexer and the output stage.
// ----------------------------------------------------------------------------
module klx_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  klx_pkg::ent_t wdata,
  output logic          full,
  input  logic          pop,
  output logic          nempty,
  output klx_pkg::ent_t rdata
);
  import klx_pkg::*;

  ent_t mem_r [2];
  logic wp_r, wp_nxt;
  logic rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full   = (cnt_r == 2'd2);
  assign nempty = (cnt_r != 2'd0);
  assign rdata  = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r ^ push;
    rp_nxt  = rp_r ^ pop;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

@@ rtl/klx_back.sv @@
// ----------------------------------------------------------------------------
// klx_back
// Output stage: sends the one or two tokens of each group, one per beat.
// ----------------------------------------------------------------------------
module klx_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_nempty,
  input  klx_pkg::ent_t q_data,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_ready,
  output klx_pkg::tok_t tok,
  output logic          tok_last
);
  import klx_pkg::*;

  ent_t cur_r;
  logic vld_r, vld_nxt;
  logic sel_r, sel_nxt;
  logic done;

  // current beat finishes its group
  assign done  = vld_r && out_ready && (!cur_r.two || sel_r);
  assign q_pop = q_nempty && (!vld_r || done);

  always_comb begin
    vld_nxt = vld_r;
    sel_nxt = sel_r;
    if (q_pop) begin
      vld_nxt = 1'b1;
      sel_nxt = 1'b0;
    end else if (done) begin
      vld_nxt = 1'b0;
      sel_nxt = 1'b0;
    end else if (vld_r && out_ready) begin
      sel_nxt = 1'b1;
    end
  end

  assign out_valid = vld_r;
  assign tok       = sel_r ? cur_r.t1 : cur_r.t0;
  assign tok_last  = !cur_r.two || sel_r;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      sel_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
      sel_r <= sel_nxt;
    end
  end

endmodule

@@ rtl/keyword_number_string_lexer_unit.sv @@
// ----------------------------------------------------------------------------
// keyword_number_string_lexer_unit
// Lexer for a line-oriented configuration text, one character per beat.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_ready carries one character byte per beat; a NUL
// byte ends a line. Output channel out_valid/out_ready carries one token per
// beat: bracket, number, keyword index, string character, string end, end of
// line or error code; out_last marks the final token caused by one character.
// A character yields zero, one or two tokens. The lexer state updates in the
// accept cycle, the token group is queued, and the first token appears on
// the output once the output stage has loaded the group from the queue.
// A character is accepted every cycle while the two-entry group queue has
// room; sustained rate is one character per cycle, bounded only by the output
// channel, which moves one token per cycle (a group sends its tokens in turn).
// When the receiver stalls, the output token holds, the queue fills and
// in_ready drops; the lexer keeps its state until more room appears.
// Synchronous reset puts the lexer in start mode with all keyword candidates
// live and empties the queue and output stage.
// ----------------------------------------------------------------------------
module keyword_number_string_lexer_unit #(
  parameter int MAX_TEXT     = 128,
  parameter int NUMBER_LIMIT = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_char_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_token_kind,
  output logic [3:0]  out_keyword_index,
  output logic [10:0] out_number_value,
  output logic [7:0]  out_text_char,
  output logic [2:0]  out_error_code,
  output logic        out_last
);
  import klx_pkg::*;

  logic acc;
  logic push;
  ent_t wdata;
  ent_t rdata;
  logic full;
  logic nempty;
  logic pop;
  tok_t tok;

  assign in_ready = !full;
  assign acc      = in_valid && in_ready;

  klx_front #(
    .MAX_TEXT     (MAX_TEXT),
    .NUMBER_LIMIT (NUMBER_LIMIT)
  ) u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .acc   (acc),
    .c     (in_char_in),
    .push  (push),
    .ent   (wdata)
  );

  klx_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wdata  (wdata),
    .full   (full),
    .pop    (pop),
    .nempty (nempty),
    .rdata  (rdata)
  );

  klx_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_nempty  (nempty),
    .q_data    (rdata),
    .q_pop     (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .tok       (tok),
    .tok_last  (out_last)
  );

  assign out_token_kind    = tok.kind;
  assign out_keyword_index = tok.kw_idx;
  assign out_number_value  = tok.num;
  assign out_text_char     = tok.ch;
  assign out_error_code    = tok.err;

endmodule
